>>> rtl/gbm_spot_path_step_assert.svh
// Assertion macros shared by the block.
`ifndef GBM_SPOT_PATH_STEP_ASSERT_SVH
`define GBM_SPOT_PATH_STEP_ASSERT_SVH
`define GSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/gsp_pkg.sv
`timescale 1ns / 1ps
package gsp_pkg;
    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic [31:0] LN2_Q30 = 32'd744261118;
    localparam int TERMS = 10;

    typedef enum logic [1:0] {
        REG_SPOT = 2'd0,
        REG_MIL  = 2'd1,
        REG_DIV  = 2'd2
    } t_reg_idx;

    // Reciprocals of 1..10 in Q1.36, rounded up so the truncated product
    // equals the exact floor for dividends below 2^31 (checked by correction).
    function automatic logic [36:0] recip(input logic [3:0] k);
        logic [36:0] r;
        case (k)
            4'd1:    r = 37'h1000000000;
            4'd2:    r = 37'h0800000000;
            4'd3:    r = 37'h0555555556;
            4'd4:    r = 37'h0400000000;
            4'd5:    r = 37'h0333333334;
            4'd6:    r = 37'h02AAAAAAAB;
            4'd7:    r = 37'h024924924A;
            4'd8:    r = 37'h0200000000;
            4'd9:    r = 37'h01C71C71C8;
            4'd10:   r = 37'h019999999A;
            default: r = 37'h1000000000;
        endcase
        return r;
    endfunction

    function automatic logic signed [63:0] sat32(input logic signed [65:0] x);
        logic signed [63:0] r;
        if (x > 66'sd2147483647) r = 64'sd2147483647;
        else if (x < -66'sd2147483648) r = -64'sd2147483648;
        else r = x[63:0];
        return r;
    endfunction
endpackage

>>> rtl/gbm_spot_path_step.sv
`timescale 1ns / 1ps
// One path date per input word: a log-Euler step with an optional Milstein term and
// escrowed dividends, in fixed point with a saturating spot output. Every product goes
// through one shared registered 33x33 multiplier, each use taking a multiply state and
// a wait state. A later-date word uses it 27 times, or 30 with the Milstein term. That
// count covers the drift, diffusion and Milstein products, the two exponent split
// products, ten Taylor terms of exp at two uses each, and the final scale. The input is
// ready again in the cycle after the result is taken. A first-date word uses the
// multiplier only for the carry product and passes the initial spot through. The input
// side is not ready while a word is in work or its result waits.
module gbm_spot_path_step
    import gsp_pkg::*;
#(
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // tdata: brownian[31:0], vol[62:32], carry_rate[94:63], date_time[125:95],
    // step_dt[156:126], dividend_pv[188:157], vol_slope[220:189], zero fill
    input  logic [223:0]      i_s_tdata,
    // tuser: first_date
    input  logic              i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // tdata: spot_value[31:0], zero fill
    output logic [31:0]       o_m_tdata,
    // tuser: overflow
    output logic              o_m_tuser
);
`include "gbm_spot_path_step_assert.svh"

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_WAIT = 6'b000100,
        S_TAY  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_spot0;
    logic r_mil, r_div;
    logic [31:0] r_prev_spot, r_prev_w, r_prev_c, r_prev_d;
    logic [31:0] r_out;
    logic r_ovf;
    logic [4:0] r_op;
    logic [3:0] r_k;
    logic r_div_ph;
    logic signed [63:0] r_acc, r_tmp, r_dw, r_h, r_m;
    logic [63:0] r_e, r_t, r_z, r_clean;
    logic [223:0] r_in;
    logic r_first;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    gsp_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    logic signed [63:0] w_in, v_in, rate_in, tm_in, dt_in, slope_in;
    logic [31:0] pv_in;
    assign w_in     = 64'(signed'(r_in[31:0]));
    assign v_in     = {33'd0, r_in[62:32]};
    assign rate_in  = 64'(signed'(r_in[94:63]));
    assign tm_in    = {33'd0, r_in[125:95]};
    assign dt_in    = {33'd0, r_in[156:126]};
    assign pv_in    = r_in[188:157];
    assign slope_in = 64'(signed'(r_in[220:189]));

    // Floor shift right of a signed product.
    function automatic logic signed [63:0] asr(input logic signed [65:0] x,
                                               input int k);
        logic signed [65:0] r;
        r = x >>> k;
        return r[63:0];
    endfunction

    // Ops run in order (OP_M..OP_MQ Milstein only), one use each; OP_TZ two per term.
    localparam logic [4:0] OP_CARRY = 5'd0, OP_H = 5'd1, OP_HDT = 5'd2,
        OP_VDW = 5'd3, OP_M = 5'd4, OP_DW2 = 5'd5, OP_MQ = 5'd6,
        OP_LOG = 5'd7, OP_Z = 5'd8, OP_TZ = 5'd9, OP_SC = 5'd10;

    logic [36:0] rcp_k;
    assign rcp_k = recip(r_k);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_op)
            OP_CARRY: begin mul_a = rate_in[32:0]; mul_b = tm_in[32:0]; end
            OP_H:     begin mul_a = v_in[32:0]; mul_b = v_in[32:0]; end
            OP_HDT:   begin mul_a = r_h[32:0]; mul_b = dt_in[32:0]; end
            OP_VDW:   begin mul_a = v_in[32:0]; mul_b = r_dw[32:0]; end
            OP_M:     begin mul_a = v_in[32:0]; mul_b = slope_in[32:0]; end
            OP_DW2:   begin mul_a = r_dw[32:0]; mul_b = r_dw[32:0]; end
            OP_MQ:    begin mul_a = r_m[32:0]; mul_b = r_tmp[32:0]; end
            OP_LOG:   begin mul_a = r_acc[32:0]; mul_b = {LOG2E_Q30[31], LOG2E_Q30}; end
            OP_Z:     begin mul_a = {1'b0, r_tmp[31:0]}; mul_b = {1'b0, LN2_Q30}; end
            OP_TZ: begin
                if (!r_div_ph) begin
                    mul_a = {2'b0, r_t[30:0]}; mul_b = {2'b0, r_z[30:0]};
                end else begin
                    mul_a = {1'b0, r_tmp[31:0]};
                    mul_b = {1'b0, rcp_k[36:5]};
                end
            end
            default: begin mul_a = {1'b0, r_clean[31:0]}; mul_b = {1'b0, r_e[31:0]}; end
        endcase
    end

    logic [31:0] div_now;
    assign div_now = r_div ? pv_in : 32'd0;

    logic s_acc, m_acc, cfg_wr;
    assign s_acc  = i_s_tvalid && o_s_tready;
    assign m_acc  = o_m_tvalid && i_m_tready;
    assign cfg_wr = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata = r_out;
    assign o_m_tuser = r_ovf;

    always_comb begin
        o_prdata = 32'd0;
        case (i_paddr[ADDR_W-1:2])
            (ADDR_W-2)'(REG_SPOT): o_prdata = r_spot0;
            (ADDR_W-2)'(REG_MIL):  o_prdata = {31'd0, r_mil};
            (ADDR_W-2)'(REG_DIV):  o_prdata = {31'd0, r_div};
            default:               o_prdata = 32'd0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_acc) n_state = S_MUL;
            S_MUL:  n_state = S_WAIT;
            S_WAIT: n_state = S_MUL;
            S_TAY:  n_state = S_MUL;
            S_FIN:  n_state = S_OUT;
            S_OUT:  if (m_acc) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_WAIT && r_op == OP_CARRY && r_first) n_state = S_FIN;
        if (r_state == S_WAIT && r_op == OP_SC) n_state = S_FIN;
    end

    logic signed [63:0] p_sh24, p_sh25;
    assign p_sh24 = asr(mul_p, 24);
    assign p_sh25 = asr(mul_p, 25);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_spot0 <= '0; r_mil <= 1'b0; r_div <= 1'b0;
            r_prev_spot <= '0; r_prev_w <= '0; r_prev_c <= '0; r_prev_d <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (i_paddr[ADDR_W-1:2])
                    (ADDR_W-2)'(REG_SPOT): r_spot0 <= i_pwdata;
                    (ADDR_W-2)'(REG_MIL):  r_mil <= i_pwdata[0];
                    (ADDR_W-2)'(REG_DIV):  r_div <= i_pwdata[0];
                    default: ;
                endcase
            end
            if (r_state == S_FIN) begin
                r_prev_spot <= r_out;
                r_prev_w <= r_in[31:0];
                r_prev_d <= pv_in;
                r_prev_c <= r_h[31:0];
            end
        end
    end

    // Datapath; payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        logic signed [63:0] s;
        logic [63:0] q;
        logic [5:0] sh;
        logic [64:0] g;
        logic ov;
        s = 64'sd0; q = 64'd0; sh = 6'd0; g = 65'd0; ov = 1'b0;
        if (r_state == S_IDLE && s_acc) begin
            r_in <= i_s_tdata;
            r_first <= i_s_tuser;
            r_op <= OP_CARRY;
            r_ovf <= 1'b0;
            r_div_ph <= 1'b0;
        end
        if (r_state == S_WAIT) begin
            case (r_op)
                OP_CARRY: begin
                    // Carry in r_h until OP_H moves it to r_m; r_acc takes its change.
                    s = sat32({{2{p_sh24[63]}}, p_sh24});
                    r_h <= s;
                    r_acc <= s - 64'(signed'(r_prev_c));
                    r_dw <= sat32(66'(w_in) - 66'(signed'(r_prev_w)));
                    if (r_first) begin
                        r_out <= r_spot0;
                    end else begin
                        if (r_div && r_prev_d > r_prev_spot) begin
                            r_clean <= '0; r_ovf <= 1'b1;
                        end else begin
                            r_clean <= {32'd0, r_prev_spot - (r_div ? r_prev_d : 32'd0)};
                        end
                    end
                    r_tmp <= s;
                    r_op <= OP_H;
                end
                OP_H: begin
                    r_m <= r_h; // hold carry_now
                    r_h <= sat32({{2{p_sh25[63]}}, p_sh25});
                    r_op <= OP_HDT;
                end
                OP_HDT: begin r_acc <= r_acc - p_sh24; r_op <= OP_VDW; end
                OP_VDW: begin
                    r_h <= r_m; // restore carry_now for the state update
                    r_op <= r_mil ? OP_M : OP_LOG;
                    if (r_mil) r_acc <= r_acc + p_sh24;
                    else r_acc <= sat32({{2{r_acc[63]}}, r_acc} + 66'(p_sh24));
                end
                OP_M: begin
                    r_m <= sat32({{2{p_sh25[63]}}, p_sh25});
                    r_op <= OP_DW2;
                end
                OP_DW2: begin
                    r_tmp <= sat32({{2{p_sh24[63]}}, p_sh24} - 66'(dt_in));
                    r_op <= OP_MQ;
                end
                OP_MQ: begin
                    r_acc <= sat32({{2{r_acc[63]}}, r_acc} + 66'(p_sh24));
                    r_op <= OP_LOG;
                end
                OP_LOG: begin
                    s = asr(mul_p, 30);
                    r_tmp <= {40'd0, s[23:0]};
                    r_acc <= s >>> 24;
                    r_op <= OP_Z;
                end
                OP_Z: begin
                    q = mul_p[63:0] >> 24;
                    r_z <= q;
                    r_t <= 64'd1 << 30;
                    r_e <= 64'd1 << 30;
                    r_k <= 4'd1;
                    r_op <= OP_TZ;
                    r_div_ph <= 1'b0;
                end
                OP_TZ: begin
                    if (!r_div_ph) begin
                        r_tmp <= 64'(mul_p[63:0] >> 30);
                        r_div_ph <= 1'b1;
                    end else begin
                        q = 64'(mul_p[63:0] >> 31);
                        if (({1'b0, q[30:0]} + 32'd1) * {28'd0, r_k} <= r_tmp[31:0])
                            q = q + 64'd1;
                        r_t <= q;
                        r_e <= r_e + q;
                        r_div_ph <= 1'b0;
                        if (r_k == 4'(TERMS)) r_op <= OP_SC;
                        r_k <= r_k + 4'd1;
                    end
                end
                default: begin
                    // prod = clean*e; shift by n-30 with saturation.
                    q = mul_p[63:0];
                    s = 64'sd30 - r_acc;
                    sh = 6'(-s);
                    if (q == 64'd0 || s >= 64'sd64) g = 65'd0;
                    else if (s >= 64'sd0) g = {1'b0, q >> s[5:0]};
                    else if (-s >= 64'sd32 || q > (64'hFFFFFFFF >> sh)) begin
                        g = 65'hFFFFFFFF; ov = 1'b1;
                    end else g = {1'b0, q << sh};
                    g = g + 65'(div_now);
                    if (g > 65'hFFFFFFFF) begin
                        g = 65'hFFFFFFFF; ov = 1'b1;
                    end
                    r_out <= g[31:0];
                    if (ov) r_ovf <= 1'b1;
                end
            endcase
        end
    end

    `GSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")
    `GSP_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_m_tvalid, !o_s_tready,
        "input ready while result pending")
    `GSP_ASSERT_NEXT(a_start, i_clk, i_rst_n, s_acc, !o_s_tready,
        "ready stayed high after accepting a word")
endmodule

>>> rtl/gsp_mul.sv
`timescale 1ns / 1ps
// Registered signed multiplier, 33 by 33 bits, shared by the sequencer.
module gsp_mul
    import gsp_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule

>>> sim/tb_gbm_spot_path_step.sv
`timescale 1ns / 1ps
module tb_gbm_spot_path_step;
    import gsp_pkg::*;

    typedef struct {
        logic [31:0] spot;
        logic        ovf;
    } t_spot_word;

    // Keeps the path state and the expected spot words.
    class t_spot_board;
        logic [31:0] init_spot;
        bit          mil_en;
        bit          div_en;
        logic [31:0] p_spot;
        logic [31:0] p_w;
        logic [31:0] p_carry;
        logic [31:0] p_div;
        t_spot_word  pending[$];
        int          errors;
        int          seen;

        function new();
            init_spot = 0;
            mil_en = 0;
            div_en = 0;
            p_spot = 0;
            p_w = 0;
            p_carry = 0;
            p_div = 0;
            errors = 0;
            seen = 0;
        endfunction

        static function longint clamp32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        static function longint asr(longint x, int k);
            return x >>> k;
        endfunction

        function void note_input(logic first, logic [223:0] d);
            longint w, v, rate, tm, dt, slope, carry_now, dw, h, expo, m, q;
            longint y, n, s;
            longint unsigned pv, dprev, dnow, clean, f, z, e, t, prod, grown, spot;
            bit ovf;
            t_spot_word r;
            w = longint'($signed(d[31:0]));
            v = longint'(d[62:32]);
            rate = longint'($signed(d[94:63]));
            tm = longint'(d[125:95]);
            dt = longint'(d[156:126]);
            pv = longint'(d[188:157]);
            slope = longint'($signed(d[220:189]));
            carry_now = clamp32(asr(rate * tm, 24));
            ovf = 0;
            if (first) begin
                spot = init_spot;
            end else begin
                dprev = div_en ? longint'(p_div) : 0;
                dnow = div_en ? pv : 0;
                dw = clamp32(w - longint'($signed(p_w)));
                h = clamp32(asr(v * v, 25));
                expo = (carry_now - longint'($signed(p_carry))) - asr(h * dt, 24)
                       + asr(v * dw, 24);
                if (dprev > longint'(p_spot)) begin
                    clean = 0;
                    ovf = 1;
                end else begin
                    clean = longint'(p_spot) - dprev;
                end
                if (mil_en) begin
                    m = clamp32(asr(v * slope, 25));
                    q = clamp32(asr(dw * dw, 24) - dt);
                    expo += asr(m * q, 24);
                end
                expo = clamp32(expo);
                y = asr(expo * 64'sd1549082005, 30);
                n = asr(y, 24);
                f = y - n * 64'sd16777216;
                z = (f * 64'd744261118) >> 24;
                e = 64'd1 << 30;
                t = 64'd1 << 30;
                for (int k = 1; k <= 10; k++) begin
                    t = ((t * z) >> 30) / k;
                    e += t;
                end
                prod = clean * e;
                s = 30 - n;
                if (prod == 0 || s >= 64) grown = 0;
                else if (s >= 0) grown = prod >> s;
                else if (-s >= 32 || prod > (64'hFFFFFFFF >> (-s))) begin
                    grown = 64'hFFFFFFFF;
                    ovf = 1;
                end else grown = prod << (-s);
                spot = grown + dnow;
                if (spot > 64'hFFFFFFFF) begin
                    spot = 64'hFFFFFFFF;
                    ovf = 1;
                end
            end
            p_spot = spot[31:0];
            p_w = w[31:0];
            p_carry = carry_now[31:0];
            p_div = pv[31:0];
            r.spot = spot[31:0];
            r.ovf = ovf;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic [31:0] spot, logic ovf);
            t_spot_word x;
            seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word spot=%h ovf=%b", $time, spot, ovf);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (spot !== x.spot) begin
                $display("%0t: spot expected %h actual %h", $time, x.spot, spot);
                errors++;
            end
            if (ovf !== x.ovf) begin
                $display("%0t: overflow expected %b actual %b", $time, x.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_psel = 0;
    logic         i_penable = 0;
    logic         i_pwrite = 0;
    logic [3:0]   i_paddr = 0;
    logic [31:0]  i_pwdata = 0;
    logic [31:0]  o_prdata;
    logic         o_pready;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [223:0] i_s_tdata = 0;
    logic         i_s_tuser = 0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [31:0]  o_m_tdata;
    logic         o_m_tuser;

    t_spot_board board;
    longint    cycles = 0;
    bit        rx_on = 0;
    int        n_sent = 0;

    gbm_spot_path_step u_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd2000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
        return $urandom_range(0, 3);
    endfunction

    // Receiver: random stalls on tready, checks each accepted word.
    always @(posedge i_clk) begin
        if (rx_on) begin
            if (o_m_tvalid && i_m_tready) board.check_result(o_m_tdata, o_m_tuser);
            i_m_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 1) == 0);
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_psel <= 1;
        i_penable <= 0;
        i_pwrite <= 1;
        i_paddr <= 4'(4 * idx);
        i_pwdata <= val;
        @(posedge i_clk);
        i_penable <= 1;
        @(posedge i_clk);
        i_psel <= 0;
        i_penable <= 0;
        i_pwrite <= 0;
        case (idx)
            REG_SPOT: board.init_spot = val;
            REG_MIL:  board.mil_en = val[0];
            default:  board.div_en = val[0];
        endcase
    endtask

    task automatic send_date(logic first, logic [223:0] d);
        int gap;
        gap = pick_gap();
        // The block is never ready right after an accept, so the extra idle wait costs nothing.
        repeat (gap + 1) @(posedge i_clk);
        i_s_tvalid <= 1;
        i_s_tuser <= first;
        i_s_tdata <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_input(first, d);
        n_sent++;
        i_s_tvalid <= 0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [223:0] pack_date(logic [31:0] w, logic [30:0] v,
            logic [31:0] rate, logic [30:0] tm, logic [30:0] dt,
            logic [31:0] pv, logic [31:0] slope);
        return {3'b000, slope, pv, dt, tm, rate, v, w};
    endfunction

    // Mostly a realistic date (one in ten is fully random): small vol, short steps, modest Brownian increments.
    function automatic logic [223:0] rand_date(int idx, logic [31:0] wprev);
        logic [31:0] w;
        logic [30:0] v, tm, dt;
        logic [31:0] rate, pv, slope;
        if ($urandom_range(0, 9) == 0) begin
            w = $urandom;
            v = 31'($urandom);
            rate = $urandom;
            tm = 31'($urandom);
            dt = 31'($urandom);
            pv = $urandom;
            slope = $urandom;
        end else begin
            dt = 31'($urandom_range(32'h0004_0000, 32'h0040_0000));
            w = wprev + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            v = 31'($urandom_range(0, 32'h0080_0000));
            rate = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            tm = 31'(idx * 32'h0004_0000);
            pv = $urandom_range(0, 32'h0020_0000);
            slope = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        end
        return pack_date(w, v, rate, tm, dt, pv, slope);
    endfunction

    initial begin
        logic [223:0] d;
        logic [31:0]  wcur;
        int           plen;
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        rx_on = 1;

        // Step from the reset state before any first date, then corner words.
        send_date(0, pack_date(32'h0100_0000, 31'h0040_0000, 0, 0, 31'h0040_0000, 0, 0));
        drain();
        reg_write(REG_SPOT, 32'h0064_0000);
        reg_write(REG_MIL, 1);
        reg_write(REG_DIV, 1);
        send_date(1, pack_date(0, 31'h0033_3333, 32'h0005_0000, 0, 0,
                               32'h0010_0000, 32'h0010_0000));
        send_date(0, pack_date(32'h0080_0000, 31'h0033_3333, 32'h0005_0000,
                               31'h0100_0000, 31'h0100_0000, 32'h0008_0000, 32'h0010_0000));
        // Dividend larger than spot clamps the clean spot.
        send_date(0, pack_date(32'h0080_0000, 31'h0033_3333, 0, 0, 31'h0100_0000,
                               32'hFFFF_FFFF, 0));
        send_date(0, pack_date(32'h0080_0000, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        // Extreme exponents: huge growth saturates, huge decay underflows.
        send_date(1, pack_date(32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                               31'h7FFF_FFFF, 0, 32'h8000_0000));
        send_date(0, pack_date(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                               31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        send_date(0, pack_date(32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                               31'h7FFF_FFFF, 0, 32'h8000_0000));
        send_date(0, pack_date(32'h8000_0000, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0));
        drain();
        reg_write(REG_SPOT, 32'hFFFF_FFFF);
        reg_write(REG_MIL, 0);
        reg_write(REG_DIV, 0);
        send_date(1, pack_date(0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        send_date(0, pack_date(32'h0010_0000, 31'h0040_0000, 32'h0100_0000, 31'h0100_0000,
                               31'h0010_0000, 32'hFFFF_FFFF, 0));
        send_date(0, pack_date(32'h0010_0000, 0, 32'h0100_0000, 31'h0100_0000, 0, 0, 0));
        drain();
        reg_write(REG_SPOT, 0);
        send_date(1, pack_date(0, 0, 0, 0, 0, 0, 0));
        send_date(0, pack_date(32'h0100_0000, 31'h0040_0000, 0, 0, 31'h0100_0000, 0, 0));
        drain();

        // Random paths under several register settings.
        for (int phase = 0; phase < 8; phase++) begin
            reg_write(REG_SPOT, (phase == 7) ? 32'hFFFF_FFFF :
                      (phase % 4 == 3) ? $urandom : $urandom_range(32'h0001_0000,
                                                                  32'h0400_0000));
            reg_write(REG_MIL, 32'(phase[0]));
            reg_write(REG_DIV, 32'(phase[1]));
            for (int i = 0; i < 240; ) begin
                plen = $urandom_range(4, 40);
                wcur = 0;
                // An occasional path without a first date continues the old state.
                if ($urandom_range(0, 7) != 0) begin
                    send_date(1, rand_date(0, 0));
                    wcur = i_s_tdata[31:0];
                    i++;
                end
                for (int j = 1; j < plen && i < 240; j++, i++) begin
                    d = rand_date(j, wcur);
                    wcur = d[31:0];
                    send_date(0, d);
                end
                if ($urandom_range(0, 5) == 0) begin
                    while (board.pending.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("Sent %0d dates in eight register phases, checked %0d spot words.",
                 n_sent, board.seen);
        $display("Covered first dates, dividend strip, Milstein and saturation cases.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
